FILE: src/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

  // Sizes of the animation state.
  localparam int NUM_TIMERS  = 6;
  localparam int NUM_GROUPS  = 5;
  localparam int BLINK_TIMER = 5;

  // Command codes carried by an input word.
  localparam logic CMD_TIME   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MONITOR   = 3'd0;
  localparam logic [2:0] REG_SLIME     = 3'd1;
  localparam logic [2:0] REG_SHORE     = 3'd2;
  localparam logic [2:0] REG_SLOW_FIRE = 3'd3;
  localparam logic [2:0] REG_FAST_FIRE = 3'd4;
  localparam logic [2:0] REG_BLINK     = 3'd5;

  // Reset values of the periods, in milliseconds.
  localparam logic [15:0] PERIOD_RESET [NUM_TIMERS] =
    '{16'd100, 16'd200, 16'd200, 16'd200, 16'd142, 16'd33};

  // Ring groups: first palette index and ring length.
  localparam logic [7:0] RING_FIRST [NUM_GROUPS] = '{8'd233, 8'd229, 8'd248, 8'd238, 8'd243};
  localparam logic [2:0] RING_LEN   [NUM_GROUPS] = '{3'd5, 3'd4, 3'd6, 3'd5, 3'd5};

  // Blinking red ramp.
  localparam logic [7:0]  BLINK_INDEX      = 8'd254;
  localparam logic [7:0]  BLINK_TOP        = 8'd60;
  localparam logic [7:0]  BLINK_STEP_RESET = 8'd252;
  localparam logic [31:0] OTHER_COLOR      = 32'hFF00FF00;
  localparam logic [31:0] ALPHA_OPAQUE     = 32'hFF000000;
  localparam logic [31:0] RED_MASK         = 32'h00FF0000;

  typedef logic [15:0] period_t;
  typedef period_t [NUM_TIMERS-1:0] period_arr_t;
  typedef logic [2:0] phase_t;

  // Animation state seen by the colour lookup.
  typedef struct packed {
    phase_t [NUM_GROUPS-1:0] phase;
    logic [7:0]              blink_level;
    logic [7:0]              blink_step;
  } anim_t;

  // Colour ROM of the ring groups.
  function automatic logic [31:0] ring_color(input logic [2:0] grp, input logic [2:0] k);
    logic [31:0] c;
    c = 32'h0;
    case (grp)
      3'd0: begin
        case (k)
          3'd0: c = 32'hFF6B6B6F;
          3'd1: c = 32'hFF63677F;
          3'd2: c = 32'hFF576B8F;
          3'd3: c = 32'hFF0093A3;
          3'd4: c = 32'hFF6BBBFF;
          default: c = 32'h0;
        endcase
      end
      3'd1: begin
        case (k)
          3'd0: c = 32'hFF006C00;
          3'd1: c = 32'hFF0B7307;
          3'd2: c = 32'hFF1B7B0F;
          3'd3: c = 32'hFF2B831B;
          default: c = 32'h0;
        endcase
      end
      3'd2: begin
        case (k)
          3'd0: c = 32'hFF533F2B;
          3'd1: c = 32'hFF4B3B2B;
          3'd2: c = 32'hFF433727;
          3'd3: c = 32'hFF3F3327;
          3'd4: c = 32'hFF372F23;
          3'd5: c = 32'hFF332B23;
          default: c = 32'h0;
        endcase
      end
      3'd3: begin
        case (k)
          3'd0: c = 32'hFFFF0000;
          3'd1: c = 32'hFFD70000;
          3'd2: c = 32'hFF932B0B;
          3'd3: c = 32'hFFFF7700;
          3'd4: c = 32'hFFFF3B00;
          default: c = 32'h0;
        endcase
      end
      3'd4: begin
        case (k)
          3'd0: c = 32'hFF470000;
          3'd1: c = 32'hFF7B0000;
          3'd2: c = 32'hFFB30000;
          3'd3: c = 32'hFF7B0000;
          3'd4: c = 32'hFF470000;
          default: c = 32'h0;
        endcase
      end
      default: c = 32'h0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/pcc_if.sv
`timescale 1ns / 1ps

// Input channel: time updates and colour lookups.
interface pcc_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_ms;
  logic [7:0]  pixel_index;

  modport source (output valid, command, now_ms, pixel_index, input ready);
  modport sink   (input valid, command, now_ms, pixel_index, output ready);
endinterface

// Result channel: one colour word per lookup.
interface pcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_color;

  modport source (output valid, argb_color, input ready);
  modport sink   (input valid, argb_color, output ready);
endinterface

FILE: src/pcc_apb_regs.sv
`timescale 1ns / 1ps

module pcc_apb_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output pcc_pkg::period_arr_t periods
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Period registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcc_pkg::NUM_TIMERS; i++) begin
        periods[i] <= pcc_pkg::PERIOD_RESET[i];
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        pcc_pkg::REG_MONITOR:   periods[0] <= pwdata[15:0];
        pcc_pkg::REG_SLIME:     periods[1] <= pwdata[15:0];
        pcc_pkg::REG_SHORE:     periods[2] <= pwdata[15:0];
        pcc_pkg::REG_SLOW_FIRE: periods[3] <= pwdata[15:0];
        pcc_pkg::REG_FAST_FIRE: periods[4] <= pwdata[15:0];
        pcc_pkg::REG_BLINK:     periods[5] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      pcc_pkg::REG_MONITOR:   prdata = {16'h0, periods[0]};
      pcc_pkg::REG_SLIME:     prdata = {16'h0, periods[1]};
      pcc_pkg::REG_SHORE:     prdata = {16'h0, periods[2]};
      pcc_pkg::REG_SLOW_FIRE: prdata = {16'h0, periods[3]};
      pcc_pkg::REG_FAST_FIRE: prdata = {16'h0, periods[4]};
      pcc_pkg::REG_BLINK:     prdata = {16'h0, periods[5]};
      default:                prdata = 32'h0;
    endcase
  end

  // A write to the blink period lands in the register on the next cycle.
  a_blink_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && reg_idx == pcc_pkg::REG_BLINK) |=> periods[5] == $past(pwdata[15:0]))
    else $error("blink period write lost");

endmodule

FILE: src/pcc_anim_state.sv
`timescale 1ns / 1ps

module pcc_anim_state (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  logic [31:0]          now_ms,
  input  pcc_pkg::period_arr_t periods,
  output pcc_pkg::anim_t       anim
);

  logic [31:0] last_update_ms [pcc_pkg::NUM_TIMERS];
  logic [pcc_pkg::NUM_TIMERS-1:0] due;
  pcc_pkg::anim_t anim_next;

  // A timer is due when its last update plus its period lies below now.
  always_comb begin
    logic [31:0] limit;
    for (int t = 0; t < pcc_pkg::NUM_TIMERS; t++) begin
      limit  = last_update_ms[t] + {16'h0, periods[t]};
      due[t] = tick && (limit < now_ms);
    end
  end

  // Next phases and blink ramp.
  always_comb begin
    logic [2:0] p;
    logic [7:0] step;
    anim_next = anim;
    for (int g = 0; g < pcc_pkg::NUM_GROUPS; g++) begin
      p = anim.phase[g] + 3'd1;
      if (p >= pcc_pkg::RING_LEN[g]) begin
        p = 3'd0;
      end
      if (due[g]) begin
        anim_next.phase[g] = p;
      end
    end
    step = anim.blink_step;
    if (anim.blink_level == 8'd0 || anim.blink_level == pcc_pkg::BLINK_TOP) begin
      step = 8'd0 - anim.blink_step;
    end
    if (due[pcc_pkg::BLINK_TIMER]) begin
      anim_next.blink_step  = step;
      anim_next.blink_level = anim.blink_level + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anim.phase       <= '0;
      anim.blink_level <= 8'd0;
      anim.blink_step  <= pcc_pkg::BLINK_STEP_RESET;
      for (int t = 0; t < pcc_pkg::NUM_TIMERS; t++) begin
        last_update_ms[t] <= 32'h0;
      end
    end else begin
      anim <= anim_next;
      for (int t = 0; t < pcc_pkg::NUM_TIMERS; t++) begin
        if (due[t]) begin
          last_update_ms[t] <= now_ms;
        end
      end
    end
  end

  // The ramp stays on multiples of four between zero and the top.
  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    anim.blink_level <= pcc_pkg::BLINK_TOP && anim.blink_level[1:0] == 2'b00 &&
    (anim.blink_step == 8'd4 || anim.blink_step == pcc_pkg::BLINK_STEP_RESET))
    else $error("blink ramp out of range");

  // The shore ring, the longest one, never passes its length.
  a_shore_phase: assert property (@(posedge clk) disable iff (rst)
    anim.phase[2] < pcc_pkg::RING_LEN[2])
    else $error("shore phase out of range");

endmodule

FILE: src/pcc_color_lookup.sv
`timescale 1ns / 1ps

module pcc_color_lookup (
  input  logic [7:0]     pixel_index,
  input  pcc_pkg::anim_t anim,
  output logic [31:0]    argb_color
);

  always_comb begin
    logic [7:0] off;
    logic [3:0] k;
    logic [7:0] red;
    argb_color = pcc_pkg::OTHER_COLOR;
    // Ring groups: rotate the offset by the phase, wrap once.
    for (int g = 0; g < pcc_pkg::NUM_GROUPS; g++) begin
      off = pixel_index - pcc_pkg::RING_FIRST[g];
      k   = {1'b0, off[2:0]} + {1'b0, anim.phase[g]};
      if (k >= {1'b0, pcc_pkg::RING_LEN[g]}) begin
        k = k - {1'b0, pcc_pkg::RING_LEN[g]};
      end
      if (pixel_index >= pcc_pkg::RING_FIRST[g] && off < {5'd0, pcc_pkg::RING_LEN[g]}) begin
        argb_color = pcc_pkg::ring_color(3'(g), k[2:0]);
      end
    end
    // Blinking red.
    red = anim.blink_step + anim.blink_level;
    if (pixel_index == pcc_pkg::BLINK_INDEX) begin
      argb_color = pcc_pkg::ALPHA_OPAQUE | (pcc_pkg::RED_MASK & {8'h0, red, 16'h0});
    end
  end

endmodule

FILE: src/palette_color_cycler.sv
`timescale 1ns / 1ps

// Colour-cycling palette for an 8-bit indexed display.
// Input channel req carries words with a command bit: a time update brings
// now_ms and advances each animation whose timer has run out; a lookup
// brings pixel_index and yields one word on rsp with its ARGB colour.
// Time updates give no result word.
// The APB port holds six 16-bit animation periods at byte addresses 4*i;
// write them only while no word is in flight.
// A lookup passes through the input register and then the result register
// before its colour is offered on rsp.
// Throughput: one word per cycle while rsp does not stall, set by the input
// register feeding the combinational colour lookup and output register.
// When rsp stalls, a lookup waits in the input register and req stays
// ready only while that register can still move on; time updates pass
// even while a result waits. Reset restores the period defaults, clears
// timers and phases, resets the blink ramp, and empties both registers.
module palette_color_cycler (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pcc_req_if.sink     req,
  pcc_rsp_if.source   rsp
);

  pcc_pkg::period_arr_t periods;
  pcc_pkg::anim_t       anim;

  logic        s1_valid;
  logic        s1_command;
  logic [31:0] s1_now_ms;
  logic [7:0]  s1_index;
  logic        out_valid;
  logic [31:0] out_color;
  logic [31:0] color;
  logic        s1_lookup;
  logic        s1_fire;
  logic        tick;

  pcc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .periods (periods)
  );

  pcc_anim_state u_anim (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .now_ms  (s1_now_ms),
    .periods (periods),
    .anim    (anim)
  );

  pcc_color_lookup u_lookup (
    .pixel_index (s1_index),
    .anim        (anim),
    .argb_color  (color)
  );

  // Flow control: a lookup needs a free output register, a time update does not.
  assign s1_lookup = s1_command == pcc_pkg::CMD_LOOKUP;
  assign s1_fire   = s1_valid && (!s1_lookup || !out_valid || rsp.ready);
  assign tick      = s1_fire && !s1_lookup;
  assign req.ready = !s1_valid || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_command <= req.command;
      s1_now_ms  <= req.now_ms;
      s1_index   <= req.pixel_index;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_lookup) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_lookup) begin
      out_color <= color;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.argb_color = out_color;

  // A result word only ever comes from a lookup that left the input register.
  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_lookup))
    else $error("result word without a lookup");

  // A lookup blocked by a stalled result stays in the input register.
  a_lookup_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_lookup && out_valid && !rsp.ready) |=> (s1_valid && s1_lookup))
    else $error("blocked lookup lost");

endmodule

FILE: bench/tb_palette_color_cycler.sv
`timescale 1ns / 1ps

module tb_palette_color_cycler;
  import pcc_pkg::*;

  // One word on the request channel.
  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [7:0]  pixel_index;
  } pcc_word_t;

  localparam logic [2:0] PERIOD_REGS [NUM_TIMERS] =
    '{REG_MONITOR, REG_SLIME, REG_SHORE, REG_SLOW_FIRE, REG_FAST_FIRE, REG_BLINK};

  // Colours of each ring group, unused slots padded with zero.
  localparam logic [31:0] RING_ROM [NUM_GROUPS][6] = '{
    '{32'hFF6B6B6F, 32'hFF63677F, 32'hFF576B8F, 32'hFF0093A3, 32'hFF6BBBFF, 32'h0},
    '{32'hFF006C00, 32'hFF0B7307, 32'hFF1B7B0F, 32'hFF2B831B, 32'h0, 32'h0},
    '{32'hFF533F2B, 32'hFF4B3B2B, 32'hFF433727, 32'hFF3F3327, 32'hFF372F23, 32'hFF332B23},
    '{32'hFFFF0000, 32'hFFD70000, 32'hFF932B0B, 32'hFFFF7700, 32'hFFFF3B00, 32'h0},
    '{32'hFF470000, 32'hFF7B0000, 32'hFFB30000, 32'hFF7B0000, 32'hFF470000, 32'h0}
  };

  // Group boundaries and the indices either side of the animated range.
  localparam logic [7:0] EDGE_INDICES [14] =
    '{8'd0, 8'd255, 8'd228, 8'd229, 8'd232, 8'd233, 8'd237,
      8'd238, 8'd242, 8'd243, 8'd247, 8'd248, 8'd253, 8'd254};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pcc_req_if req_ch ();
  pcc_rsp_if rsp_ch ();

  palette_color_cycler u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Our own copy of the periods and the animation state.
  period_arr_t periods;
  logic [31:0] last_step_ms [NUM_TIMERS];
  phase_t      ring_phase [NUM_GROUPS];
  logic [7:0]  blink_level;
  logic [7:0]  blink_step;

  pcc_word_t   pending_words [$];
  logic [31:0] expected_colors [$];
  pcc_word_t   next_word;
  logic [31:0] want_color;
  int          mismatches = 0;
  int          src_idle_pct = 10;
  int          sink_idle_pct = 10;
  logic [31:0] clock_ms = 32'h0;
  int unsigned max_step_ms = 153;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advances every animation whose timer has run out at time now.
  function automatic void advance_animations(input logic [31:0] now);
    logic [31:0] limit;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      limit = last_step_ms[t] + {16'h0, periods[t]};
      if (limit < now) begin
        last_step_ms[t] = now;
        if (t == BLINK_TIMER) begin
          if (blink_level == 8'd0 || blink_level == BLINK_TOP)
            blink_step = 8'd0 - blink_step;
          blink_level = blink_level + blink_step;
        end else if (ring_phase[t] == RING_LEN[t] - 3'd1) begin
          ring_phase[t] = '0;
        end else begin
          ring_phase[t] = ring_phase[t] + 3'd1;
        end
      end
    end
  endfunction

  // Colour of a palette index under the present animation state.
  function automatic logic [31:0] palette_color(input logic [7:0] idx);
    logic [31:0] color;
    logic [7:0]  red;
    int          rel;
    color = OTHER_COLOR;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      rel = int'(idx) - int'(RING_FIRST[g]);
      if (rel >= 0 && rel < int'(RING_LEN[g]))
        color = RING_ROM[g][(rel + int'(ring_phase[g])) % int'(RING_LEN[g])];
    end
    if (idx == BLINK_INDEX) begin
      red = blink_step + blink_level;
      color = ALPHA_OPAQUE | (RED_MASK & {8'h00, red, 16'h0000});
    end
    return color;
  endfunction

  // Request driver: predicts each accepted word, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.command == CMD_LOOKUP)
          expected_colors.push_back(palette_color(req_ch.pixel_index));
        else
          advance_animations(req_ch.now_ms);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          next_word = pending_words.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.command     <= next_word.command;
          req_ch.now_ms      <= next_word.now_ms;
          req_ch.pixel_index <= next_word.pixel_index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each colour word with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_colors.size() == 0) begin
          $error("argb_color: expected nothing, got %h", rsp_ch.argb_color);
          mismatches++;
        end else begin
          want_color = expected_colors.pop_front();
          if (rsp_ch.argb_color !== want_color) begin
            $error("argb_color: expected %h, got %h", want_color, rsp_ch.argb_color);
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  task automatic queue_word(input logic cmd, input logic [31:0] now, input logic [7:0] idx);
    pcc_word_t w;
    w.command     = cmd;
    w.now_ms      = now;
    w.pixel_index = idx;
    pending_words.push_back(w);
  endtask

  // Mostly a clock that runs forward by steps near the periods, with the odd
  // jump anywhere; lookups lean towards the animated indices.
  task automatic queue_random_words(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 40) begin
        if (roll < 3)
          clock_ms = $urandom;
        else
          clock_ms = clock_ms + $urandom_range(max_step_ms, 0);
        queue_word(CMD_TIME, clock_ms, 8'($urandom));
      end else if (roll < 85) begin
        queue_word(CMD_LOOKUP, $urandom, 8'($urandom_range(255, 229)));
      end else begin
        queue_word(CMD_LOOKUP, $urandom, 8'($urandom));
      end
    end
  endtask

  // Holds off until every word has gone in and every colour has come out,
  // then lets a time update still in the pipeline settle.
  task automatic wait_idle();
    while (pending_words.size() != 0 || req_ch.valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes all six periods over the register port.
  task automatic apply_periods(input period_arr_t vals);
    int unsigned top;
    top = 0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {PERIOD_REGS[t], 2'b00};
      pwdata  <= {16'($urandom), vals[t]};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      periods[t] = vals[t];
      if (vals[t] > top) top = vals[t];
    end
    max_step_ms = top * 3 / 4 + 3;
  endtask

  initial begin
    period_arr_t vals;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_TIME;
    req_ch.now_ms      = '0;
    req_ch.pixel_index = '0;
    rsp_ch.ready       = 1'b0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      periods[t]      = PERIOD_RESET[t];
      last_step_ms[t] = '0;
    end
    for (int g = 0; g < NUM_GROUPS; g++) ring_phase[g] = '0;
    blink_level = '0;
    blink_step  = BLINK_STEP_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words: every group boundary, a time of zero that must not fire,
    // an all-ones time that fires every timer, then a wrapped limit.
    foreach (EDGE_INDICES[i]) queue_word(CMD_LOOKUP, 32'h0, EDGE_INDICES[i]);
    queue_word(CMD_TIME, 32'h0000_0000, 8'hFF);
    queue_word(CMD_TIME, 32'hFFFF_FFFF, 8'h00);
    for (int g = 0; g < NUM_GROUPS; g++) queue_word(CMD_LOOKUP, 32'hFFFF_FFFF, RING_FIRST[g]);
    queue_word(CMD_LOOKUP, 32'h0, BLINK_INDEX);
    queue_word(CMD_TIME, 32'h7FFF_FFFF, 8'h00);
    queue_word(CMD_LOOKUP, 32'h0, BLINK_INDEX);
    queue_word(CMD_LOOKUP, 32'h0, 8'd237);
    clock_ms = 32'h7FFF_FFFF;
    queue_random_words(170);
    wait_idle();

    // Zero periods: every strictly later time steps every animation.
    vals = '0;
    apply_periods(vals);
    @(negedge clk);
    queue_random_words(170);
    wait_idle();

    // Longest periods, and a stretch with no idling on either side.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    vals = '1;
    apply_periods(vals);
    @(negedge clk);
    queue_random_words(160);
    wait_idle();
    src_idle_pct  = 10;
    sink_idle_pct = 10;

    // Short random periods.
    for (int t = 0; t < NUM_TIMERS; t++) vals[t] = 16'($urandom_range(300, 0));
    apply_periods(vals);
    @(negedge clk);
    queue_random_words(160);
    wait_idle();

    // Periods anywhere in range.
    for (int t = 0; t < NUM_TIMERS; t++) vals[t] = 16'($urandom);
    apply_periods(vals);
    @(negedge clk);
    queue_random_words(130);
    wait_idle();

    // Each period at one extreme or the other.
    for (int t = 0; t < NUM_TIMERS; t++) vals[t] = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    apply_periods(vals);
    @(negedge clk);
    queue_random_words(130);
    wait_idle();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
